[rtl/ckvt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckvt_pkg - shared definitions for the compacting key/value table
// Store geometry, port widths and the operation and status codes.
// ----------------------------------------------------------------------------
package ckvt_pkg;

    // Store geometry
    localparam int DEPTH       = 32;
    localparam int KEY_WIDTH   = 64;
    localparam int VALUE_WIDTH = 64;

    // Internal widths derived from the geometry
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed port widths
    localparam int OP_W       = 2;
    localparam int KEY_PORT_W = 64;
    localparam int VAL_PORT_W = 64;
    localparam int STATUS_W   = 2;
    localparam int INDEX_W    = 5;
    localparam int COUNT_W    = 6;
    localparam int CAP_W      = 6;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(32);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

endpackage
`default_nettype wire

[rtl/compacting_key_value_table_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_key_value_table_unit - packed key/value table with linear search
// Insert appends a pair, remove deletes one and closes the gap, lookup
// returns the position and value of a key. One result per transfer.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+-----------------------------------------
//  input    | in_valid / in_ready     | opcode, lookup_key, new_value
//  output   | out_valid / out_ready   | status, entry_index, found_value,
//           |                         | entry_count
//  config   | cfg_wr_en (no wait)     | cfg_wr_data (capacity)
//
//  The search reads and compares each entry in turn until the key matches or
//  the entries run out; a remove then reads each later entry and writes it one
//  place lower, and a lookup then reads the value of the matching entry.
//  Reset clears the fill count and sets capacity to 32; the stores stay as is.
//  in_ready is high only while idle. The next item is taken while a result
//  waits in the output register, and stalls at its end until that frees up.
// ----------------------------------------------------------------------------
module compacting_key_value_table_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              in_valid,
    output      logic                              in_ready,
    input  wire logic [ckvt_pkg::OP_W-1:0]         opcode,
    input  wire logic [ckvt_pkg::KEY_PORT_W-1:0]   lookup_key,
    input  wire logic [ckvt_pkg::VAL_PORT_W-1:0]   new_value,

    output      logic                              out_valid,
    input  wire logic                              out_ready,
    output      logic [ckvt_pkg::STATUS_W-1:0]     status,
    output      logic [ckvt_pkg::INDEX_W-1:0]      entry_index,
    output      logic [ckvt_pkg::VAL_PORT_W-1:0]   found_value,
    output      logic [ckvt_pkg::COUNT_W-1:0]      entry_count,

    input  wire logic                              cfg_wr_en,
    input  wire logic [ckvt_pkg::CAP_W-1:0]        cfg_wr_data
);

    localparam int IDX_W = ckvt_pkg::IDX_W;
    localparam int CNT_W = ckvt_pkg::CNT_W;
    localparam int KW    = ckvt_pkg::KEY_WIDTH;
    localparam int VW    = ckvt_pkg::VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_VAL_RD,
        S_VAL_CAP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } state_t;

    // Key and value stores: one write and one registered read per cycle
    logic [KW-1:0] key_mem   [ckvt_pkg::DEPTH];
    logic [VW-1:0] value_mem [ckvt_pkg::DEPTH];

    logic [KW-1:0] rd_key_reg;
    logic [VW-1:0] rd_val_reg;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KW-1:0]    wr_key;
    logic [VW-1:0]    wr_val;
    logic [IDX_W-1:0] rd_addr;

    // Sequencer and working registers
    state_t                 state_reg,      state_next;
    ckvt_pkg::op_t          op_reg,         op_next;
    logic [KW-1:0]          key_reg,        key_next;
    logic [VW-1:0]          val_reg,        val_next;
    logic [CNT_W-1:0]       ptr_reg,        ptr_next;
    logic [CNT_W-1:0]       fill_count_reg, fill_count_next;
    logic [ckvt_pkg::CAP_W-1:0] capacity_reg, capacity_next;

    // Result being built
    ckvt_pkg::status_t      res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_idx_reg,    res_idx_next;
    logic [VW-1:0]          res_found_reg,  res_found_next;

    // Output register
    logic                   out_valid_reg,  out_valid_next;
    ckvt_pkg::status_t      out_status_reg, out_status_next;
    logic [IDX_W-1:0]       out_idx_reg,    out_idx_next;
    logic [VW-1:0]          out_found_reg,  out_found_next;
    logic [CNT_W-1:0]       out_count_reg,  out_count_next;

    logic [CNT_W-1:0]       capacity_limit;
    ckvt_pkg::op_t          in_op;

    // Clamp capacity to the store depth
    always_comb
    begin
        if (int'(capacity_reg) >= ckvt_pkg::DEPTH)
        begin
            capacity_limit = CNT_W'(ckvt_pkg::DEPTH);
        end
        else
        begin
            capacity_limit = CNT_W'(capacity_reg);
        end
    end

    assign in_op   = ckvt_pkg::op_t'(opcode);
    assign rd_addr = IDX_W'(ptr_reg);

    // Sequencer next-state logic
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        ptr_next        = ptr_reg;
        fill_count_next = fill_count_reg;
        capacity_next   = capacity_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_found_next  = out_found_reg;
        out_count_next  = out_count_reg;

        wr_en   = 1'b0;
        wr_addr = IDX_W'(ptr_reg);
        wr_key  = key_reg;
        wr_val  = val_reg;

        if (cfg_wr_en)
        begin
            capacity_next = cfg_wr_data;
        end

        // Drop the result once it has been transferred
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = in_op;
                    key_next        = lookup_key[KW-1:0];
                    val_next        = new_value[VW-1:0];
                    ptr_next        = '0;
                    res_status_next = ckvt_pkg::ST_OK;
                    res_idx_next    = '0;
                    res_found_next  = '0;
                    if (in_op == ckvt_pkg::OP_NOP)
                    begin
                        state_next = S_DONE;
                    end
                    else if (in_op == ckvt_pkg::OP_INSERT && fill_count_reg >= capacity_limit)
                    begin
                        res_status_next = ckvt_pkg::ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SRCH_RD;
                    end
                end
            end

            S_SRCH_RD:
            begin
                if (ptr_reg >= fill_count_reg)
                begin
                    // Key absent: append on insert, else report it missing
                    if (op_reg == ckvt_pkg::OP_INSERT)
                    begin
                        wr_en           = 1'b1;
                        wr_addr         = IDX_W'(fill_count_reg);
                        res_idx_next    = IDX_W'(fill_count_reg);
                        fill_count_next = fill_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        res_status_next = ckvt_pkg::ST_MISSING;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP:
            begin
                if (rd_key_reg == key_reg)
                begin
                    res_idx_next = IDX_W'(ptr_reg);
                    case (op_reg)
                        ckvt_pkg::OP_INSERT:
                        begin
                            res_status_next = ckvt_pkg::ST_DUP;
                            res_idx_next    = '0;
                            state_next      = S_DONE;
                        end
                        ckvt_pkg::OP_REMOVE:
                        begin
                            ptr_next   = ptr_reg + CNT_W'(1);
                            state_next = S_SHIFT_RD;
                        end
                        ckvt_pkg::OP_LOOKUP:
                        begin
                            state_next = S_VAL_RD;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
                else
                begin
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = S_SRCH_RD;
                end
            end

            S_VAL_RD:
            begin
                state_next = S_VAL_CAP;
            end

            S_VAL_CAP:
            begin
                res_found_next = rd_val_reg;
                state_next     = S_DONE;
            end

            S_SHIFT_RD:
            begin
                if (ptr_reg >= fill_count_reg)
                begin
                    fill_count_next = fill_count_reg - CNT_W'(1);
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_WR;
                end
            end

            S_SHIFT_WR:
            begin
                // Move entry ptr down one place
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(ptr_reg - CNT_W'(1));
                wr_key     = rd_key_reg;
                wr_val     = rd_val_reg;
                ptr_next   = ptr_reg + CNT_W'(1);
                state_next = S_SHIFT_RD;
            end

            S_DONE:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = res_idx_reg;
                    out_found_next  = res_found_reg;
                    out_count_next  = fill_count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= ckvt_pkg::OP_NOP;
            key_reg        <= '0;
            val_reg        <= '0;
            ptr_reg        <= '0;
            fill_count_reg <= '0;
            capacity_reg   <= ckvt_pkg::CAPACITY_RESET;
            res_status_reg <= ckvt_pkg::ST_OK;
            res_idx_reg    <= '0;
            res_found_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ckvt_pkg::ST_OK;
            out_idx_reg    <= '0;
            out_found_reg  <= '0;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            val_reg        <= val_next;
            ptr_reg        <= ptr_next;
            fill_count_reg <= fill_count_next;
            capacity_reg   <= capacity_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_idx_reg    <= out_idx_next;
            out_found_reg  <= out_found_next;
            out_count_reg  <= out_count_next;
        end
    end

    // Key and value stores
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            value_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= value_mem[rd_addr];
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign entry_index = ckvt_pkg::INDEX_W'(out_idx_reg);
    assign found_value = ckvt_pkg::VAL_PORT_W'(out_found_reg);
    assign entry_count = ckvt_pkg::COUNT_W'(out_count_reg);

`ifndef NO_ASSERTIONS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(fill_count_reg) <= ckvt_pkg::DEPTH)
        else $error("fill count above store depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg != $past(fill_count_reg) |->
            (fill_count_reg == $past(fill_count_reg) + CNT_W'(1)) ||
            (fill_count_reg == $past(fill_count_reg) - CNT_W'(1)))
        else $error("fill count moved by more than one");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ckvt_pkg::ST_OK |->
            out_idx_reg == '0 && out_found_reg == '0)
        else $error("failed operation carries index or value");

    a_no_write_at_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !wr_en)
        else $error("store written while accepting an item");
`endif

endmodule
`default_nettype wire
